// File: design/urrx_pkg.sv
// ----------------------------------------------------------------------------
// urrx_pkg
// Shared types, register indexes and constants for the UART register block
// with receive FIFO and service-request nodes.
// ----------------------------------------------------------------------------
package urrx_pkg;

    localparam int REG_WORDS = 64;
    localparam int REG_AW    = 6;
    localparam int RX_DEPTH_DEFAULT = 16;

    localparam logic [1:0] ACT_READ  = 2'd0;
    localparam logic [1:0] ACT_WRITE = 2'd1;
    localparam logic [1:0] ACT_RECV  = 2'd2;

    localparam logic [REG_AW-1:0] IDX_ID    = 6'h02;
    localparam logic [REG_AW-1:0] IDX_TBUF  = 6'h08;
    localparam logic [REG_AW-1:0] IDX_RBUF  = 6'h09;
    localparam logic [REG_AW-1:0] IDX_FSTAT = 6'h12;
    localparam logic [REG_AW-1:0] IDX_TSRC  = 6'h3C;
    localparam logic [REG_AW-1:0] IDX_TBSRC = 6'h3D;
    localparam logic [REG_AW-1:0] IDX_RSRC  = 6'h3E;
    localparam logic [REG_AW-1:0] IDX_ESRC  = 6'h3F;

    localparam logic [31:0] ID_WORD   = 32'h0048_C000;
    localparam logic [31:0] NODE_KEEP = 32'h0000_1FFF;
    localparam logic [31:0] NODE_PEND = 32'h0000_2000;
    localparam int NODE_EN_BIT  = 12;
    localparam int NODE_PEND_BIT = 13;
    localparam int NODE_CLR_BIT = 14;
    localparam int NODE_SET_BIT = 15;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    typedef struct packed {
        logic [1:0]  action;
        logic [7:0]  reg_offset;
        logic [31:0] write_data;
        logic [7:0]  rx_byte;
        logic        rx_last;
    } req_t;

    typedef struct packed {
        logic [31:0] read_data;
        logic        tx_valid;
        logic [7:0]  tx_byte;
        logic        irq_valid;
        logic [7:0]  irq_number;
    } rsp_t;

endpackage

// File: design/urrx_ram.sv
// ----------------------------------------------------------------------------
// urrx_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module urrx_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                       clk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic                                       re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: design/uart_regs_rx_fifo_service_requests.sv
// ----------------------------------------------------------------------------
// uart_regs_rx_fifo_service_requests
// UART register window with a receive FIFO and four service-request nodes.
//
//   channel   signals           transfer when
//   request   start, busy, req  start high and busy low at a rising edge
//   response  done, rsp         done high for one cycle, no back pressure
//
// For each item, the accept edge reads the register file and
// the FIFO store, and the following cycle modifies, writes back and loads
// the response, which shows on rsp with done in the next cycle while the
// block is already ready again. Busy covers the write-back cycle, so no
// read can meet a pending write to the same entry. After reset the register
// file reads its reset values through per-word valid flags.
// ----------------------------------------------------------------------------
module uart_regs_rx_fifo_service_requests
    import urrx_pkg::*;
#(
    parameter int RX_DEPTH = RX_DEPTH_DEFAULT
) (
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  req_t req,
    output logic done,
    output rsp_t rsp
);

    localparam int PW = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
    localparam int CW = $clog2(RX_DEPTH + 1);

    state_t state_reg, state_next;
    logic   accept;
    logic   exec;

    req_t              req_reg;
    logic [REG_AW-1:0] rd_idx_reg;
    logic [REG_AW-1:0] rd_idx;
    logic [REG_AW-1:0] idx;
    logic [REG_WORDS-1:0] valid_reg;

    logic [PW-1:0] head_reg, head_next;
    logic [PW-1:0] tail_reg, tail_next;
    logic [CW-1:0] cnt_reg, cnt_next;

    logic              rf_we;
    logic [REG_AW-1:0] rf_waddr;
    logic [31:0]       rf_wdata;
    logic [31:0]       rf_q;
    logic [31:0]       old_word;
    logic [31:0]       raised;
    logic              pend;

    logic       rx_we;
    logic [7:0] rx_q;

    rsp_t rsp_reg, rsp_next;
    logic done_reg;

    assign accept = start && !busy;
    assign idx    = req_reg.reg_offset[7:2];

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        busy = 1'b0;
        exec = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
            end
            ST_EXEC:
            begin
                busy = 1'b1;
                exec = 1'b1;
            end
            default:
            begin
                busy = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        rd_idx = req.reg_offset[7:2];
        case (req.action)
            ACT_READ:
            begin
                if (req.reg_offset[7:2] == IDX_RBUF)
                begin
                    rd_idx = IDX_RSRC;
                end
            end
            ACT_WRITE:
            begin
                if (req.reg_offset[7:2] == IDX_TBUF)
                begin
                    rd_idx = IDX_TSRC;
                end
            end
            ACT_RECV:
            begin
                rd_idx = IDX_RSRC;
            end
            default:
            begin
                rd_idx = req.reg_offset[7:2];
            end
        endcase
    end

    urrx_ram #(
        .WIDTH (32),
        .DEPTH (REG_WORDS)
    ) u_regfile (
        .clk   (clk),
        .we    (rf_we),
        .waddr (rf_waddr),
        .wdata (rf_wdata),
        .re    (accept),
        .raddr (rd_idx),
        .rdata (rf_q)
    );

    urrx_ram #(
        .WIDTH (8),
        .DEPTH (RX_DEPTH)
    ) u_rxstore (
        .clk   (clk),
        .we    (rx_we),
        .waddr (tail_reg),
        .wdata (req_reg.rx_byte),
        .re    (accept),
        .raddr (head_reg),
        .rdata (rx_q)
    );

    always_comb
    begin
        if (valid_reg[rd_idx_reg])
        begin
            old_word = rf_q;
        end
        else if (rd_idx_reg == IDX_ID)
        begin
            old_word = ID_WORD;
        end
        else
        begin
            old_word = '0;
        end
    end

    assign raised = old_word | NODE_PEND;

    always_comb
    begin
        rf_we     = 1'b0;
        rf_waddr  = rd_idx_reg;
        rf_wdata  = old_word;
        rx_we     = 1'b0;
        head_next = head_reg;
        tail_next = tail_reg;
        cnt_next  = cnt_reg;
        rsp_next  = '0;
        pend      = old_word[NODE_PEND_BIT];
        case (req_reg.action)
            ACT_READ:
            begin
                if (idx == IDX_RBUF)
                begin
                    if (cnt_reg != '0)
                    begin
                        rsp_next.read_data = 32'(rx_q);
                        head_next = (head_reg == PW'(RX_DEPTH - 1)) ? '0 : head_reg + 1'b1;
                        cnt_next  = cnt_reg - 1'b1;
                    end
                    if (cnt_next == '0)
                    begin
                        rf_we    = 1'b1;
                        rf_wdata = old_word & ~NODE_PEND;
                    end
                end
                else if (idx == IDX_FSTAT)
                begin
                    rsp_next.read_data = 32'(cnt_reg) & 32'h0000_000F;
                end
                else
                begin
                    rsp_next.read_data = old_word;
                end
            end
            ACT_WRITE:
            begin
                if (idx == IDX_TBUF)
                begin
                    rsp_next.tx_valid = 1'b1;
                    rsp_next.tx_byte  = req_reg.write_data[7:0];
                    rf_we    = 1'b1;
                    rf_wdata = raised;
                    if (raised[NODE_EN_BIT] && (raised[7:0] != 8'd0))
                    begin
                        rsp_next.irq_valid  = 1'b1;
                        rsp_next.irq_number = raised[7:0];
                    end
                end
                else if (idx inside {IDX_TSRC, IDX_TBSRC, IDX_RSRC, IDX_ESRC})
                begin
                    if (req_reg.write_data[NODE_SET_BIT])
                    begin
                        pend = 1'b1;
                    end
                    if (req_reg.write_data[NODE_CLR_BIT])
                    begin
                        pend = 1'b0;
                    end
                    rf_we    = 1'b1;
                    rf_wdata = (req_reg.write_data & NODE_KEEP) | (pend ? NODE_PEND : '0);
                end
                else
                begin
                    rf_we    = 1'b1;
                    rf_waddr = idx;
                    rf_wdata = req_reg.write_data;
                end
            end
            ACT_RECV:
            begin
                if (cnt_reg < CW'(RX_DEPTH))
                begin
                    rx_we     = 1'b1;
                    tail_next = (tail_reg == PW'(RX_DEPTH - 1)) ? '0 : tail_reg + 1'b1;
                    cnt_next  = cnt_reg + 1'b1;
                end
                if (req_reg.rx_last)
                begin
                    rf_we    = 1'b1;
                    rf_wdata = raised;
                    if (raised[NODE_EN_BIT] && (raised[7:0] != 8'd0))
                    begin
                        rsp_next.irq_valid  = 1'b1;
                        rsp_next.irq_number = raised[7:0];
                    end
                end
            end
            default:
            begin
                rsp_next = '0;
            end
        endcase
        rf_we = rf_we && exec;
        rx_we = rx_we && exec;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            valid_reg <= '0;
            head_reg  <= '0;
            tail_reg  <= '0;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= exec;
            if (rf_we)
            begin
                valid_reg[rf_waddr] <= 1'b1;
            end
            if (exec)
            begin
                head_reg <= head_next;
                tail_reg <= tail_next;
                cnt_reg  <= cnt_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg    <= req;
            rd_idx_reg <= rd_idx;
        end
        if (exec)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

    a_done_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("Response strobe while the block is busy.");

    a_accept_to_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy ##1 done))
        else $error("Accepted transfer did not complete in two cycles.");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(RX_DEPTH))
        else $error("Receive FIFO count exceeds its depth.");

    a_tx_source: assert property (@(posedge clk) disable iff (!rst_n)
        (done && rsp.tx_valid) |-> (req_reg.action == ACT_WRITE && idx == IDX_TBUF))
        else $error("Transmit byte without a transmit-buffer write.");

endmodule

// File: test/uart_regs_rx_fifo_service_requests_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uart_regs_rx_fifo_service_requests_test
// Self-checking testbench for the UART register block. A directed sequence
// covers the identification word, empty and full receive FIFO, transmit
// writes and the service-request nodes. Random bus reads, writes and
// received bytes follow, in bursts. Each accepted transfer is predicted by
// a scoreboard and compared with the response that the block returns.
// ----------------------------------------------------------------------------
module uart_regs_rx_fifo_service_requests_test;
    import urrx_pkg::*;

    localparam logic [1:0] ACT_NONE = 2'd3;
    localparam int RX_DEPTH = RX_DEPTH_DEFAULT;
    localparam int ITEM_COUNT = 2000;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 16;

    class uart_reg_scoreboard;
        logic [31:0] regs [REG_WORDS];
        logic [7:0] fifo_mem [RX_DEPTH];
        int fifo_head;
        int fifo_tail;
        int fifo_count;
        rsp_t reply_q [$];
        int mismatches;

        function new();
            foreach (regs[i])
            begin
                regs[i] = '0;
            end
            regs[IDX_ID] = ID_WORD;
            fifo_head = 0;
            fifo_tail = 0;
            fifo_count = 0;
            mismatches = 0;
        endfunction

        function rsp_t raise_node(logic [REG_AW-1:0] idx, rsp_t r);
            regs[idx] = regs[idx] | NODE_PEND;
            if (regs[idx][NODE_EN_BIT] && regs[idx][7:0] != 8'd0)
            begin
                r.irq_valid = 1'b1;
                r.irq_number = regs[idx][7:0];
            end
            return r;
        endfunction

        function void note(req_t q);
            rsp_t r;
            logic [REG_AW-1:0] idx;
            logic pend;
            r = '0;
            idx = q.reg_offset[7:2];
            case (q.action)
                ACT_READ:
                begin
                    if (idx == IDX_RBUF)
                    begin
                        if (fifo_count > 0)
                        begin
                            r.read_data = {24'd0, fifo_mem[fifo_head]};
                            fifo_head = (fifo_head + 1) % RX_DEPTH;
                            fifo_count--;
                        end
                        if (fifo_count == 0)
                        begin
                            regs[IDX_RSRC] = regs[IDX_RSRC] & ~NODE_PEND;
                        end
                    end
                    else if (idx == IDX_FSTAT)
                    begin
                        r.read_data = 32'(fifo_count % 16);
                    end
                    else
                    begin
                        r.read_data = regs[idx];
                    end
                end
                ACT_WRITE:
                begin
                    if (idx == IDX_TBUF)
                    begin
                        r.tx_valid = 1'b1;
                        r.tx_byte = q.write_data[7:0];
                        r = raise_node(IDX_TSRC, r);
                    end
                    else if (idx inside {IDX_TSRC, IDX_TBSRC, IDX_RSRC, IDX_ESRC})
                    begin
                        pend = regs[idx][NODE_PEND_BIT];
                        if (q.write_data[NODE_SET_BIT])
                        begin
                            pend = 1'b1;
                        end
                        if (q.write_data[NODE_CLR_BIT])
                        begin
                            pend = 1'b0;
                        end
                        regs[idx] = (q.write_data & NODE_KEEP) | (pend ? NODE_PEND : 32'd0);
                    end
                    else
                    begin
                        regs[idx] = q.write_data;
                    end
                end
                ACT_RECV:
                begin
                    if (fifo_count < RX_DEPTH)
                    begin
                        fifo_mem[fifo_tail] = q.rx_byte;
                        fifo_tail = (fifo_tail + 1) % RX_DEPTH;
                        fifo_count++;
                    end
                    if (q.rx_last)
                    begin
                        r = raise_node(IDX_RSRC, r);
                    end
                end
                default:
                begin
                end
            endcase
            reply_q.push_back(r);
        endfunction

        function void check(rsp_t got);
            rsp_t want;
            if (reply_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("%0t: response with no transfer outstanding: %h", $time, got);
                end
                return;
            end
            want = reply_q.pop_front();
            if (got.read_data !== want.read_data || got.tx_valid !== want.tx_valid ||
                got.tx_byte !== want.tx_byte || got.irq_valid !== want.irq_valid ||
                got.irq_number !== want.irq_number)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("%0t: expected read_data=%h tx=%b/%h irq=%b/%h", $time,
                             want.read_data, want.tx_valid, want.tx_byte,
                             want.irq_valid, want.irq_number);
                    $display("%0t:      got read_data=%h tx=%b/%h irq=%b/%h", $time,
                             got.read_data, got.tx_valid, got.tx_byte,
                             got.irq_valid, got.irq_number);
                end
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    req_t req;
    logic done;
    rsp_t rsp;
    int unsigned cycles = 0;
    uart_reg_scoreboard sb = new();

    uart_regs_rx_fifo_service_requests i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .req   (req),
        .done  (done),
        .rsp   (rsp)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    always @(posedge clk)
    begin
        cycles = cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            sb.check(rsp);
        end
    end

    function automatic req_t make_req(logic [1:0] act, logic [7:0] off, logic [31:0] data,
                                      logic [7:0] rx_byte, logic rx_last);
        req_t q;
        q.action = act;
        q.reg_offset = off;
        q.write_data = data;
        q.rx_byte = rx_byte;
        q.rx_last = rx_last;
        return q;
    endfunction

    function automatic req_t random_req(bit filling);
        req_t q;
        int pick;
        q = make_req(ACT_READ, 8'($urandom), $urandom, 8'($urandom),
                     $urandom_range(0, 3) == 0);
        pick = $urandom_range(0, 99);
        if (pick < (filling ? 45 : 15))
        begin
            q.action = ACT_RECV;
        end
        else if (pick < 60)
        begin
            case ($urandom_range(0, 5))
                0, 1, 2: q.reg_offset = {IDX_RBUF, q.reg_offset[1:0]};
                3: q.reg_offset = {IDX_FSTAT, q.reg_offset[1:0]};
                default: ;
            endcase
        end
        else if (pick < 95)
        begin
            q.action = ACT_WRITE;
            case ($urandom_range(0, 4))
                0: q.reg_offset = {IDX_TBUF, q.reg_offset[1:0]};
                1, 2:
                begin
                    q.reg_offset = {IDX_TSRC + 6'($urandom_range(0, 3)), q.reg_offset[1:0]};
                    q.write_data[NODE_EN_BIT] = ($urandom_range(0, 4) != 0);
                end
                default: ;
            endcase
        end
        else
        begin
            q.action = ACT_NONE;
        end
        return q;
    endfunction

    task automatic send(input req_t item);
        @(negedge clk);
        start <= 1'b1;
        req <= item;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
        sb.note(item);
    endtask

    task automatic hold_off(input int n);
        @(negedge clk);
        start <= 1'b0;
        req <= random_req($urandom_range(0, 1));
        repeat (n - 1) @(negedge clk);
    endtask

    task automatic wait_drained();
        hold_off(1);
        while (sb.reply_q.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic run_directed();
        send(make_req(ACT_READ, {IDX_ID, 2'b11}, '1, 8'hFF, 1'b1));
        send(make_req(ACT_READ, {IDX_RBUF, 2'b00}, '0, 8'h00, 1'b0));
        send(make_req(ACT_READ, {IDX_FSTAT, 2'b01}, '0, 8'h00, 1'b0));
        send(make_req(ACT_WRITE, {IDX_TSRC, 2'b00}, 32'hFFFF_D0FF, 8'h00, 1'b0));
        send(make_req(ACT_WRITE, {IDX_TBUF, 2'b10}, 32'h0000_00A5, 8'h00, 1'b0));
        send(make_req(ACT_READ, {IDX_TBUF, 2'b00}, '0, 8'h00, 1'b0));
        send(make_req(ACT_READ, {IDX_TSRC, 2'b00}, '0, 8'h00, 1'b0));
        send(make_req(ACT_WRITE, {IDX_ESRC, 2'b00}, 32'h0000_9000, 8'h00, 1'b0));
        send(make_req(ACT_WRITE, {IDX_RSRC, 2'b00}, 32'h0000_1001, 8'h00, 1'b0));
        for (int k = 0; k < RX_DEPTH; k++)
        begin
            send(make_req(ACT_RECV, 8'h00, '0,
                          (k == 0) ? 8'h00 : (k == 1) ? 8'hFF : 8'($urandom), k == 7));
        end
        send(make_req(ACT_RECV, 8'h00, '0, 8'h5A, 1'b1));
        send(make_req(ACT_READ, {IDX_FSTAT, 2'b00}, '0, 8'h00, 1'b0));
        send(make_req(ACT_READ, {IDX_RBUF, 2'b00}, '0, 8'h00, 1'b0));
        send(make_req(ACT_WRITE, {IDX_RBUF, 2'b00}, '1, 8'h00, 1'b0));
        send(make_req(ACT_READ, {IDX_RSRC, 2'b00}, '0, 8'h00, 1'b0));
        send(make_req(ACT_NONE, 8'hFF, '1, 8'hFF, 1'b1));
    endtask

    initial
    begin
        int sent;
        int burst;
        rst_n = 1'b0;
        start = 1'b0;
        req = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        run_directed();
        wait_drained();

        sent = 0;
        while (sent < ITEM_COUNT)
        begin
            burst = $urandom_range(1, 24);
            for (int k = 0; k < burst && sent < ITEM_COUNT; k++)
            begin
                send(random_req(((sent / 150) % 2) == 0));
                sent++;
                if (sent % 500 == 0)
                begin
                    wait_drained();
                end
            end
            if ($urandom_range(0, 3) != 0)
            begin
                hold_off($urandom_range(1, 6));
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.mismatches == 0 && sb.reply_q.size() == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
